// ----- rtl/assert_macros.svh -----
// Assertion macros used by the siren sequencer back end (sps_back).
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds on every clock edge outside reset.
`define SPS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define SPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- rtl/sps_pkg.sv -----
// Types, codes and pattern tables for the siren pattern sequencer.
// Used by sps_front, sps_back and siren_pattern_sequencer; no dependencies.
`timescale 1ns / 1ps

package sps_pkg;

    localparam int DUR_BITS     = 16;
    localparam int ELAPSED_BITS = DUR_BITS + 10;
    localparam int PHASE_BITS   = 11;
    localparam int MS_PER_SEC   = 1000;

    localparam int Q_DEPTH     = 2;
    localparam int QIDX_BITS   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [2:0] PAT_STEADY  = 3'd0;
    localparam logic [2:0] PAT_TEMP3   = 3'd1;
    localparam logic [2:0] PAT_TEMP4   = 3'd2;
    localparam logic [2:0] PAT_PANIC   = 3'd3;
    localparam logic [2:0] PAT_MEDICAL = 3'd4;
    localparam logic [2:0] NO_PATTERN  = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_BAD_START,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  pat_sel;
        logic [15:0] run_secs;
    } t_in_item;

    typedef struct packed {
        logic        siren_on;
        logic        running;
        logic [2:0]  active_pattern;
        logic [15:0] active_duration;
        logic        start_error;
    } t_out_item;

    // Classified command as it waits between front and back.
    typedef struct packed {
        t_op                     op;
        logic [2:0]              pattern;
        logic [DUR_BITS-1:0]     dur;
        logic [ELAPSED_BITS-1:0] limit_ms;
    } t_cmd_item;

    typedef struct packed {
        logic      valid;
        t_cmd_item item;
    } t_cmd_port;

    // Phase length in ms for a pattern, step and phase half.
    function automatic logic [PHASE_BITS-1:0] phase_len(input logic [2:0] pat,
                                                        input logic [1:0] step,
                                                        input logic       off);
        logic [PHASE_BITS-1:0] len;
        len = '0;
        case (pat)
            PAT_TEMP3: begin
                if (!off) len = (step == 2'd3) ? PHASE_BITS'(0) : PHASE_BITS'(500);
                else if (step == 2'd2) len = PHASE_BITS'(1500);
                else if (step == 2'd3) len = PHASE_BITS'(0);
                else len = PHASE_BITS'(500);
            end
            PAT_TEMP4: begin
                if (off && step == 2'd3) len = PHASE_BITS'(2000);
                else len = PHASE_BITS'(500);
            end
            PAT_PANIC: begin
                len = (step == 2'd0) ? PHASE_BITS'(250) : PHASE_BITS'(0);
            end
            PAT_MEDICAL: begin
                if (step != 2'd0) len = PHASE_BITS'(0);
                else len = off ? PHASE_BITS'(2000) : PHASE_BITS'(500);
            end
            default: len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] step_total(input logic [2:0] pat);
        logic [2:0] n;
        case (pat)
            PAT_TEMP3:   n = 3'd3;
            PAT_TEMP4:   n = 3'd4;
            PAT_PANIC:   n = 3'd1;
            PAT_MEDICAL: n = 3'd1;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/sps_front.sv -----
// Front end: decodes each accepted beat into a command and queues it.
// Depends on sps_pkg.
`timescale 1ns / 1ps

module sps_front
    import sps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output t_cmd_port o_cmd,
    input  logic      i_cmd_pop
);

    t_cmd_item             r_mem [Q_DEPTH];
    logic [QIDX_BITS-1:0]  r_wp, r_rp;
    logic [QCNT_BITS-1:0]  r_cnt;
    logic [QIDX_BITS-1:0]  n_wp, n_rp;
    logic [QCNT_BITS-1:0]  n_cnt;
    t_cmd_item             dec;
    logic                  wr, rd;

    always_comb begin
        dec.pattern  = i_item.pat_sel;
        dec.dur      = DUR_BITS'(i_item.run_secs);
        // precompute the expiry point so the back end only compares
        dec.limit_ms = ELAPSED_BITS'(dec.dur) * ELAPSED_BITS'(MS_PER_SEC);
        unique case (i_item.cmd)
            CMD_TICK:  dec.op = OP_TICK;
            CMD_START: dec.op = (i_item.pat_sel >= NO_PATTERN) ? OP_BAD_START : OP_START;
            CMD_STOP:  dec.op = OP_STOP;
            default:   dec.op = OP_NOP;
        endcase
    end

    assign full = (r_cnt == QCNT_BITS'(Q_DEPTH));
    assign wr   = push && !full;
    assign rd   = i_cmd_pop && (r_cnt != '0);

    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.item  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr) n_wp = (r_wp == QIDX_BITS'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        if (rd) n_rp = (r_rp == QIDX_BITS'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        if (wr && !rd) n_cnt = r_cnt + 1'b1;
        else if (rd && !wr) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= dec;
    end

endmodule

// ----- rtl/sps_back.sv -----
// Back end: runs the pattern state for each queued command and queues results.
// Depends on sps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sps_back
    import sps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_port i_cmd,
    output logic      o_cmd_pop,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic                    r_run, n_run;
    logic [2:0]              r_pat, n_pat;
    logic [DUR_BITS-1:0]     r_dur, n_dur;
    logic [ELAPSED_BITS-1:0] r_limit, n_limit;
    logic [1:0]              r_step, n_step;
    logic                    r_off, n_off;
    logic [PHASE_BITS-1:0]   r_phase, n_phase;
    logic [ELAPSED_BITS-1:0] r_elapsed, n_elapsed;
    logic                    n_err;

    t_out_item               r_mem [Q_DEPTH];
    logic [QIDX_BITS-1:0]    r_wp, r_rp;
    logic [QCNT_BITS-1:0]    r_cnt;
    logic                    res_full, wr, rd;
    t_out_item               res;
    logic [PHASE_BITS-1:0]   ph_inc;
    logic [ELAPSED_BITS-1:0] el_inc;
    logic [2:0]              step_inc;
    logic                    stop_wr, bad_wr;
    logic [DUR_BITS+3:0]     run_state;

    assign res_full  = (r_cnt == QCNT_BITS'(Q_DEPTH));
    assign wr        = i_cmd.valid && !res_full;
    assign o_cmd_pop = wr;
    assign empty     = (r_cnt == '0);
    assign rd        = pop && !empty;
    assign o_result  = r_mem[r_rp];

    assign ph_inc   = r_phase + 1'b1;
    assign el_inc   = r_elapsed + 1'b1;
    assign step_inc = {1'b0, r_step} + 3'd1;

    assign stop_wr   = wr && (i_cmd.item.op == OP_STOP);
    assign bad_wr    = wr && (i_cmd.item.op == OP_BAD_START);
    assign run_state = {r_run, r_pat, r_dur};

    always_comb begin
        n_run     = r_run;
        n_pat     = r_pat;
        n_dur     = r_dur;
        n_limit   = r_limit;
        n_step    = r_step;
        n_off     = r_off;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_err     = 1'b0;
        case (i_cmd.item.op)
            OP_TICK: begin
                if (r_run && r_pat < NO_PATTERN) begin
                    if (r_dur != '0 && el_inc >= r_limit) begin
                        // expiry: drop back to idle
                        n_run     = 1'b0;
                        n_pat     = NO_PATTERN;
                        n_dur     = '0;
                        n_limit   = '0;
                        n_step    = '0;
                        n_off     = 1'b0;
                        n_phase   = '0;
                        n_elapsed = '0;
                    end else begin
                        if (r_dur != '0) n_elapsed = el_inc;
                        if (r_pat != PAT_STEADY) begin
                            if (ph_inc >= phase_len(r_pat, r_step, r_off)) begin
                                n_phase = '0;
                                n_off   = !r_off;
                                if (r_off) begin
                                    n_step = (step_inc >= step_total(r_pat)) ? 2'd0
                                                                             : step_inc[1:0];
                                end
                            end else begin
                                n_phase = ph_inc;
                            end
                        end
                    end
                end
            end
            OP_START: begin
                n_run     = 1'b1;
                n_pat     = i_cmd.item.pattern;
                n_dur     = i_cmd.item.dur;
                n_limit   = i_cmd.item.limit_ms;
                n_step    = '0;
                n_off     = 1'b0;
                n_phase   = '0;
                n_elapsed = '0;
            end
            OP_STOP: begin
                n_run     = 1'b0;
                n_pat     = NO_PATTERN;
                n_dur     = '0;
                n_limit   = '0;
                n_step    = '0;
                n_off     = 1'b0;
                n_phase   = '0;
                n_elapsed = '0;
            end
            OP_BAD_START: n_err = 1'b1;
            default: ;
        endcase

        res.siren_on        = n_run && !n_off;
        res.running         = n_run;
        res.active_pattern  = n_pat;
        res.active_duration = 16'(n_dur);
        res.start_error     = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_pat     <= NO_PATTERN;
            r_dur     <= '0;
            r_limit   <= '0;
            r_step    <= '0;
            r_off     <= 1'b0;
            r_phase   <= '0;
            r_elapsed <= '0;
        end else if (wr) begin
            r_run     <= n_run;
            r_pat     <= n_pat;
            r_dur     <= n_dur;
            r_limit   <= n_limit;
            r_step    <= n_step;
            r_off     <= n_off;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == QIDX_BITS'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == QIDX_BITS'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (wr && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= res;
    end

    `SPS_ASSERT_ALWAYS(a_res_cnt_bound, i_clk, i_rst_n, r_cnt <= QCNT_BITS'(Q_DEPTH))
    `SPS_ASSERT_IMPLY(a_run_has_pattern, i_clk, i_rst_n, r_run, r_pat < NO_PATTERN)
    `SPS_ASSERT_NEXT(a_stop_clears, i_clk, i_rst_n, stop_wr, !r_run && r_pat == NO_PATTERN)
    `SPS_ASSERT_NEXT(a_bad_start_holds, i_clk, i_rst_n, bad_wr, run_state == $past(run_state))

endmodule

// ----- rtl/siren_pattern_sequencer.sv -----
// Top level of the siren pattern sequencer: front decoder, command queue, back end.
// Depends on sps_pkg, sps_front and sps_back.
//
//  channel   handshake          payload    beat
//  input     push / full        i_item     tick, start or stop
//  result    empty / pop        o_result   siren level and status, one per input
//
// One beat per cycle sustained while the result side keeps popping; a beat waits in the
// command queue, then its result is written to the result queue and can be popped.
// The pattern state update is combinational, so the back end retires a command
// every cycle while the result queue has room.
// Reset is synchronous and active low; it empties both queues and idles the siren.
// A stalled result side fills the result queue, then the command queue, then full rises.
`timescale 1ns / 1ps

module siren_pattern_sequencer
    import sps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    t_cmd_port cmd;
    logic      cmd_pop;

    sps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    sps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_cmd_pop (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for siren_pattern_sequencer: streams tick/start/stop beats,
// predicts the siren level and status for each one and checks every result beat.
// Depends on sps_pkg and the siren_pattern_sequencer RTL.
`timescale 1ns / 1ps

module testbench;
    import sps_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned RANDOM_BEATS = 1200;
    localparam int unsigned LONG_RUNS    = 1;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned MAX_REPORTS  = 10;

    // Tracks the siren state seen from the input side and holds the
    // results still owed by the block, oldest first.
    class siren_scoreboard;
        bit              run_on;
        logic [2:0]      pat;
        logic [15:0]     dur;
        logic [1:0]      step_idx;
        bit              off;
        int unsigned     phase_ms;
        int unsigned     elapsed_ms;
        t_out_item       owed_q[$];
        int unsigned     n_bad;

        function new();
            halt();
            n_bad = 0;
        endfunction

        function void halt();
            run_on     = 1'b0;
            pat        = NO_PATTERN;
            dur        = '0;
            step_idx   = '0;
            off        = 1'b0;
            phase_ms   = 0;
            elapsed_ms = 0;
        endfunction

        function void note_input(t_in_item it);
            t_out_item   res;
            bit          err;
            bit          expired;
            int unsigned lim;
            int unsigned nsteps;
            int unsigned nxt;
            err     = 1'b0;
            expired = 1'b0;
            case (it.cmd)
                CMD_TICK: begin
                    if (run_on && pat < NO_PATTERN) begin
                        if (dur != 0) begin
                            elapsed_ms++;
                            if (elapsed_ms >= int'(dur) * MS_PER_SEC) begin
                                halt();
                                expired = 1'b1;
                            end
                        end
                        // steady never changes phase
                        if (!expired && pat != PAT_STEADY) begin
                            phase_ms++;
                            case (pat)
                                PAT_TEMP3: lim = (off && step_idx == 2'd2) ? 1500 : 500;
                                PAT_TEMP4: lim = (off && step_idx == 2'd3) ? 2000 : 500;
                                PAT_PANIC: lim = 250;
                                default:   lim = off ? 2000 : 500;
                            endcase
                            case (pat)
                                PAT_TEMP3: nsteps = 3;
                                PAT_TEMP4: nsteps = 4;
                                default:   nsteps = 1;
                            endcase
                            if (phase_ms >= lim) begin
                                phase_ms = 0;
                                if (!off) begin
                                    off = 1'b1;
                                end else begin
                                    off = 1'b0;
                                    nxt = int'(step_idx) + 1;
                                    step_idx = (nxt >= nsteps) ? 2'd0 : nxt[1:0];
                                end
                            end
                        end
                    end
                end
                CMD_START: begin
                    if (it.pat_sel >= NO_PATTERN) begin
                        err = 1'b1;
                    end else begin
                        halt();
                        run_on = 1'b1;
                        pat    = it.pat_sel;
                        dur    = it.run_secs;
                    end
                end
                CMD_STOP: begin
                    halt();
                end
                default: ;
            endcase
            res.siren_on        = run_on && !off;
            res.running         = run_on;
            res.active_pattern  = pat;
            res.active_duration = dur;
            res.start_error     = err;
            owed_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected result beat: on=%b run=%b pat=%0d dur=%0d err=%b",
                             got.siren_on, got.running, got.active_pattern,
                             got.active_duration, got.start_error);
                return;
            end
            want = owed_q.pop_front();
            if (got.siren_on !== want.siren_on || got.running !== want.running ||
                got.active_pattern !== want.active_pattern ||
                got.active_duration !== want.active_duration ||
                got.start_error !== want.start_error) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS) begin
                    $display("bad result: want on=%b run=%b pat=%0d dur=%0d err=%b",
                             want.siren_on, want.running, want.active_pattern,
                             want.active_duration, want.start_error);
                    $display("            got  on=%b run=%b pat=%0d dur=%0d err=%b",
                             got.siren_on, got.running, got.active_pattern,
                             got.active_duration, got.start_error);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    siren_scoreboard sb;
    int unsigned     n_sent = 0;
    int unsigned     n_checked = 0;
    int unsigned     n_cycles = 0;
    bit              tx_quiet = 1'b0;

    siren_pattern_sequencer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("siren_pattern_sequencer: mismatch");
            $finish;
        end
    end

    // Mostly no idle, some short gaps, a few long ones.
    function automatic int unsigned idle_len(bit quiet);
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic t_in_item mk_beat(logic [1:0] c, logic [2:0] p, logic [15:0] d);
        t_in_item it;
        it.cmd      = c;
        it.pat_sel  = p;
        it.run_secs = d;
        return it;
    endfunction

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(t_in_item it);
        int unsigned gap;
        gap = idle_len(tx_quiet);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_input(it);
        n_sent++;
    endtask

    // Result side: random stalls, one long hold-off to back up the input.
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          held_once;
        bit          rx_quiet;
        stall_left = 0;
        hold_left  = 0;
        held_once  = 1'b0;
        rx_quiet   = 1'b0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (pop && !empty) begin
                sb.check_result(o_result);
                n_checked++;
                if ($urandom_range(0, 63) == 0) rx_quiet = ~rx_quiet;
                stall_left = idle_len(rx_quiet);
            end
            if (!held_once && n_checked >= 500) begin
                held_once = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    initial begin
        int unsigned n_long;
        int unsigned ticks;
        int unsigned r;
        logic [2:0]  pid;
        logic [15:0] dur;
        sb = new();
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_item  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle commands, unknown patterns, every pattern, field extremes
        send_beat(mk_beat(CMD_TICK, 3'd7, 16'hFFFF));
        send_beat(mk_beat(CMD_STOP, 3'd0, 16'h0000));
        send_beat(mk_beat(CMD_UNUSED, 3'd7, 16'hFFFF));
        send_beat(mk_beat(CMD_START, 3'd7, 16'hFFFF));
        send_beat(mk_beat(CMD_START, PAT_STEADY, 16'hFFFF));
        send_beat(mk_beat(CMD_TICK, 3'd0, 16'h0000));
        send_beat(mk_beat(CMD_START, NO_PATTERN, 16'h0001));
        send_beat(mk_beat(CMD_START, 3'd6, 16'h8000));
        send_beat(mk_beat(CMD_UNUSED, 3'd0, 16'h0000));
        send_beat(mk_beat(CMD_START, PAT_TEMP3, 16'h0000));
        send_beat(mk_beat(CMD_TICK, 3'd5, 16'h5555));
        send_beat(mk_beat(CMD_START, PAT_TEMP4, 16'h0001));
        send_beat(mk_beat(CMD_TICK, 3'd2, 16'hAAAA));
        send_beat(mk_beat(CMD_START, PAT_PANIC, 16'h8000));
        send_beat(mk_beat(CMD_TICK, 3'd1, 16'h7FFF));
        send_beat(mk_beat(CMD_START, PAT_MEDICAL, 16'h7FFF));
        send_beat(mk_beat(CMD_TICK, 3'd4, 16'h0001));
        send_beat(mk_beat(CMD_STOP, 3'd7, 16'hFFFF));
        send_beat(mk_beat(CMD_TICK, 3'd3, 16'h0000));
        send_beat(mk_beat(CMD_START, PAT_STEADY, 16'h0000));
        send_beat(mk_beat(CMD_STOP, 3'd5, 16'h1234));

        // Episodes: a start, a run of ticks with a little noise, maybe a stop.
        // The first episode runs a one-second start past its expiry.
        n_long = 0;
        while (n_sent < RANDOM_BEATS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 19);
            if (n_long < LONG_RUNS) ticks = $urandom_range(1000, 1100);
            else if (r < 15)        ticks = $urandom_range(1, 150);
            else                    ticks = $urandom_range(150, 300);
            pid = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            r = $urandom_range(0, 9);
            if (ticks >= 1000) begin
                pid = 3'($urandom_range(0, 4));
                dur = 16'd1;
            end
            else if (r < 4)     dur = 16'd0;
            else if (r < 7)     dur = 16'd1;
            else if (r < 8)     dur = 16'd2;
            else                dur = 16'($urandom_range(0, 65535));
            send_beat(mk_beat(CMD_START, pid, dur));
            if (ticks >= 1000) n_long++;
            repeat (ticks) begin
                if (ticks < 1000 && $urandom_range(0, 99) < 3)
                    send_beat(mk_beat(2'($urandom_range(1, 3)), 3'($urandom_range(0, 7)),
                                      16'($urandom_range(0, 65535))));
                else
                    send_beat(mk_beat(CMD_TICK, 3'($urandom_range(0, 7)),
                                      16'($urandom_range(0, 65535))));
            end
            if ($urandom_range(0, 2) == 0)
                send_beat(mk_beat(CMD_STOP, 3'($urandom_range(0, 7)),
                                  16'($urandom_range(0, 65535))));
        end
        push <= 1'b0;

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.owed_q.size() == 0) begin
            $display("siren_pattern_sequencer: match");
        end else begin
            $display("siren_pattern_sequencer: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_front.sv
rtl/sps_back.sv
rtl/siren_pattern_sequencer.sv
tb/testbench.sv
